/* design/wcb_pkg.sv */
// Shared types, constants and command/result codes for the write-combining buffer.
// No dependencies; imported by wcb_ram users, wcb_ctrl and write_combining_buffer.
package wcb_pkg;

  localparam int ENTRIES       = 8;
  localparam int BLOCK_BYTES   = 8192;
  localparam int FILE_TAG_BITS = 16;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int SCAN_W = $clog2(ENTRIES + 1);
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int CNT_W  = OFF_W + 1;
  localparam int TAG_W  = 16;
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 14;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 16;

  localparam logic [CNT_W-1:0]  UNEVEN_MASK   = CNT_W'(11'o3777);
  localparam logic [CNT_W:0]    BLOCK_END     = (CNT_W + 1)'(BLOCK_BYTES);
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = TMO_W'(5);

  localparam logic [2:0] CMD_WRITE    = 3'd0;
  localparam logic [2:0] CMD_READ     = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_SYNC     = 3'd3;
  localparam logic [2:0] CMD_DISCARD  = 3'd4;
  localparam logic [2:0] CMD_SYNC_ALL = 3'd5;

  localparam logic [2:0] KIND_WRITE_OUT = 3'd0;
  localparam logic [2:0] KIND_ACK       = 3'd1;
  localparam logic [2:0] KIND_READ_HIT  = 3'd2;
  localparam logic [2:0] KIND_READ_MISS = 3'd3;
  localparam logic [2:0] KIND_DONE      = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_VOUT, S_WUPD, S_WOUT, S_ACK,
    S_RDEC, S_RMISS, S_SCAN, S_SDEC, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TAG_W-1:0]  file;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  count;
    logic              clean;
    logic              more;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] deadline;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

/* design/wcb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/wcb_ctrl.sv */
// Command sequencer: entry tags in flops, entry metadata in a wcb_ram instance,
// read-modify-write and scan over entries. Depends on wcb_pkg and wcb_ram.
module wcb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [2:0]                    cmd,
  input  logic [wcb_pkg::TAG_W-1:0]     file_tag,
  input  logic [wcb_pkg::ADDR_W-1:0]    byte_offset,
  input  logic [wcb_pkg::LEN_W-1:0]     byte_length,
  input  logic [wcb_pkg::TIME_W-1:0]    now_time,
  input  logic [wcb_pkg::TMO_W-1:0]     flush_timeout,
  output logic                          res_valid,
  input  logic                          res_ready,
  output wcb_pkg::result_t              res
);
  import wcb_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]               cmd_r;
  logic [FILE_TAG_BITS-1:0] file_r;
  logic [ADDR_W-1:0]        base_r;
  logic [OFF_W-1:0]         boff_r;
  logic [CNT_W-1:0]         len_r;
  logic [LEN_W-1:0]         rawlen_r;
  logic [TIME_W-1:0]        now_r;

  logic                     valid_r  [ENTRIES];
  logic [FILE_TAG_BITS-1:0] efile_r  [ENTRIES];
  logic [ADDR_W-1:0]        ebase_r  [ENTRIES];
  logic                     uneven_r [ENTRIES];

  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  ptr_r;
  logic              new_r, new_nxt;
  logic [SCAN_W-1:0] idx_r, idx_nxt;
  logic              more_r, more_nxt;
  logic [OFF_W-1:0]  nstart_r, nstart_nxt;
  logic [CNT_W-1:0]  ncount_r, ncount_nxt;
  logic [CNT_W-1:0]  ack_r, ack_nxt;

  logic              ram_re, ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  meta_t             ram_wdata, rdata;

  logic              clr_one, install, ptr_adv;
  logic [ENTRIES-1:0] clr_mask;

  logic [ENTRIES-1:0] hit_vec, free_vec, uneven_vec, cand_vec, scan_vec, same_vec;
  logic [IDX_W-1:0]   hit_idx, cand_idx, scan_idx;
  logic               clean;

  logic [CNT_W-1:0]  room, len_clamp;
  logic [OFF_W-1:0]  old_start, up_start;
  logic [CNT_W-1:0]  old_count, up_count, rd_diff, rd_len;
  logic              full;

  wcb_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign room      = CNT_W'(BLOCK_BYTES) - CNT_W'(byte_offset[OFF_W-1:0]);
  assign len_clamp = (32'(byte_length) > 32'(room)) ? room : CNT_W'(byte_length);

  always_comb begin
    hit_idx  = '0;
    cand_idx = '0;
    scan_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && efile_r[i] == file_r && ebase_r[i] == base_r;
      free_vec[i]   = !valid_r[i];
      uneven_vec[i] = valid_r[i] && uneven_r[i];
      cand_vec[i]   = free_vec[i] || uneven_vec[i];
      scan_vec[i]   = valid_r[i] && (cmd_r != CMD_SYNC || efile_r[i] == file_r) &&
                      SCAN_W'(i) >= idx_r;
      same_vec[i]   = valid_r[i] && efile_r[i] == efile_r[cur_r] && IDX_W'(i) != cur_r;
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx  = IDX_W'(i);
      if (cand_vec[i]) cand_idx = IDX_W'(i);
      if (scan_vec[i]) scan_idx = IDX_W'(i);
    end
    clean = (same_vec == '0);
  end

  assign old_start = new_r ? boff_r : rdata.start;
  assign old_count = new_r ? '0 : rdata.count;
  assign up_start  = (boff_r < old_start) ? boff_r : old_start;
  assign up_count  = (CNT_W'(boff_r) >= old_count) ? old_count + len_r
                                                   : CNT_W'(boff_r) + len_r;
  assign full      = ((CNT_W + 1)'(up_start) + (CNT_W + 1)'(up_count)) == BLOCK_END;
  assign rd_diff   = (rdata.count > CNT_W'(boff_r)) ? rdata.count - CNT_W'(boff_r) : '0;
  assign rd_len    = (32'(rd_diff) > 32'(rawlen_r)) ? CNT_W'(rawlen_r) : rd_diff;

  always_comb begin
    state_nxt  = state_r;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    ram_re     = 1'b0;
    ram_raddr  = cur_r;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    clr_one    = 1'b0;
    clr_mask   = '0;
    install    = 1'b0;
    ptr_adv    = 1'b0;
    cur_nxt    = cur_r;
    new_nxt    = new_r;
    idx_nxt    = idx_r;
    more_nxt   = more_r;
    nstart_nxt = nstart_r;
    ncount_nxt = ncount_r;
    ack_nxt    = ack_r;
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          idx_nxt   = '0;
          more_nxt  = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_r)
          CMD_WRITE: begin
            if (hit_vec != '0) begin
              cur_nxt   = hit_idx;
              new_nxt   = 1'b0;
              ram_re    = 1'b1;
              ram_raddr = hit_idx;
              state_nxt = S_WUPD;
            end else if (cand_vec != '0) begin
              cur_nxt = cand_idx;
              if (free_vec[cand_idx]) begin
                new_nxt   = 1'b1;
                state_nxt = S_WUPD;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cand_idx;
                state_nxt = S_VOUT;
              end
            end else begin
              cur_nxt   = ptr_r;
              ram_re    = 1'b1;
              ram_raddr = ptr_r;
              ptr_adv   = 1'b1;
              state_nxt = S_VOUT;
            end
          end
          CMD_READ: begin
            if (hit_vec != '0) begin
              cur_nxt   = hit_idx;
              ram_re    = 1'b1;
              ram_raddr = hit_idx;
              state_nxt = S_RDEC;
            end else begin
              state_nxt = S_RMISS;
            end
          end
          CMD_TICK, CMD_SYNC, CMD_SYNC_ALL: state_nxt = S_SCAN;
          CMD_DISCARD: begin
            for (int i = 0; i < ENTRIES; i++) begin
              clr_mask[i] = valid_r[i] && efile_r[i] == file_r;
            end
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_VOUT: begin
        new_nxt = 1'b1;
        if (rdata.count == '0) begin
          clr_one   = 1'b1;
          state_nxt = S_WUPD;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_WRITE_OUT;
          res.file  = TAG_W'(efile_r[cur_r]);
          res.addr  = ebase_r[cur_r] + ADDR_W'(rdata.start);
          res.count = LEN_W'(rdata.count);
          res.clean = clean;
          if (res_ready) begin
            clr_one   = 1'b1;
            state_nxt = S_WUPD;
          end
        end
      end
      S_WUPD: begin
        install    = 1'b1;
        nstart_nxt = up_start;
        ncount_nxt = up_count;
        if (full) begin
          ack_nxt   = up_count;
          state_nxt = S_WOUT;
        end else begin
          ram_we             = 1'b1;
          ram_wdata.start    = up_start;
          ram_wdata.count    = up_count;
          ram_wdata.deadline = now_r + TIME_W'(flush_timeout);
          ack_nxt            = len_r;
          state_nxt          = S_ACK;
        end
      end
      S_WOUT: begin
        res_valid = 1'b1;
        res.kind  = KIND_WRITE_OUT;
        res.file  = TAG_W'(efile_r[cur_r]);
        res.addr  = ebase_r[cur_r] + ADDR_W'(nstart_r);
        res.count = LEN_W'(ncount_r);
        res.clean = clean;
        if (res_ready) begin
          clr_one   = 1'b1;
          state_nxt = S_ACK;
        end
      end
      S_ACK: begin
        res_valid = 1'b1;
        res.kind  = KIND_ACK;
        res.count = LEN_W'(ack_r);
        res.last  = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      S_RDEC: begin
        if (rdata.start != '0) begin
          if (rdata.count == '0) begin
            clr_one   = 1'b1;
            state_nxt = S_RMISS;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_WRITE_OUT;
            res.file  = TAG_W'(efile_r[cur_r]);
            res.addr  = ebase_r[cur_r] + ADDR_W'(rdata.start);
            res.count = LEN_W'(rdata.count);
            res.clean = clean;
            if (res_ready) begin
              clr_one   = 1'b1;
              state_nxt = S_RMISS;
            end
          end
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_READ_HIT;
          res.count = LEN_W'(rd_len);
          res.last  = 1'b1;
          if (res_ready) state_nxt = S_IDLE;
        end
      end
      S_RMISS: begin
        res_valid = 1'b1;
        res.kind  = KIND_READ_MISS;
        res.last  = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_vec != '0) begin
          cur_nxt   = scan_idx;
          ram_re    = 1'b1;
          ram_raddr = scan_idx;
          idx_nxt   = SCAN_W'(scan_idx) + SCAN_W'(1);
          state_nxt = S_SDEC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SDEC: begin
        if (cmd_r == CMD_TICK && !(rdata.deadline < now_r)) begin
          more_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end else if (rdata.count == '0) begin
          clr_one   = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_WRITE_OUT;
          res.file  = TAG_W'(efile_r[cur_r]);
          res.addr  = ebase_r[cur_r] + ADDR_W'(rdata.start);
          res.count = LEN_W'(rdata.count);
          res.clean = clean;
          if (res_ready) begin
            clr_one   = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        res.kind  = KIND_DONE;
        res.more  = (cmd_r == CMD_TICK) && more_r;
        res.last  = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ptr_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (ptr_adv) begin
        ptr_r <= (ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : ptr_r + IDX_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (clr_mask[i] || (clr_one && cur_r == IDX_W'(i))) begin
          valid_r[i] <= 1'b0;
        end else if (install && cur_r == IDX_W'(i)) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    new_r    <= new_nxt;
    idx_r    <= idx_nxt;
    more_r   <= more_nxt;
    nstart_r <= nstart_nxt;
    ncount_r <= ncount_nxt;
    ack_r    <= ack_nxt;
    if (cmd_ready && cmd_valid) begin
      cmd_r    <= cmd;
      file_r   <= file_tag[FILE_TAG_BITS-1:0];
      base_r   <= {byte_offset[ADDR_W-1:OFF_W], OFF_W'(0)};
      boff_r   <= byte_offset[OFF_W-1:0];
      len_r    <= len_clamp;
      rawlen_r <= byte_length;
      now_r    <= now_time;
    end
    if (install) begin
      efile_r[cur_r]  <= file_r;
      ebase_r[cur_r]  <= base_r;
      uneven_r[cur_r] <= (up_count & UNEVEN_MASK) != '0;
    end
  end

endmodule

/* design/write_combining_buffer.sv */
// Top level of the write-combining buffer: stream ports, timeout register, result register.
// Depends on wcb_pkg and wcb_ctrl.
//
// Usage: commands arrive on the in_ stream (tuser = command, tdata = file tag, byte
// offset, byte length, current time). Each command yields one or more results on the
// out_ stream (tuser = kind, tdata = file, address, count, clean, more pending); the
// final result of a command carries out_tlast. Write-outs come before the closing
// ack, miss or done.
// One command is handled at a time. A tick, file sync or sync-all visits the valid
// entries, up to all eight, one by one (a file sync only those of its file), reading
// each entry's metadata from the RAM before it decides on that entry.
// The next command is accepted once the current one has handed its last result to the
// output register, even while that result still waits to be taken.
// A stalled receiver holds the result register and halts the sequencer at its next result.
// Reset empties all entries, clears the round-robin pointer and sets the flush
// timeout to 5 ticks; cfg_ writes are taken whenever presented and belong between
// commands, while nothing is in flight.
module write_combining_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // file_tag[15:0], byte_offset[47:16], byte_length[61:48],
                                  // now_time[93:62], zero[95:94]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_file[15:0], out_address[47:16], out_count[61:48],
                                  // file_clean[62], more_pending[63]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import wcb_pkg::*;

  logic [TMO_W-1:0] timeout_r;
  logic             out_valid_r;
  result_t          out_r;
  logic             res_valid, res_ready;
  result_t          res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  wcb_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (in_tvalid),
    .cmd_ready     (in_tready),
    .cmd           (in_tuser),
    .file_tag      (in_tdata[15:0]),
    .byte_offset   (in_tdata[47:16]),
    .byte_length   (in_tdata[61:48]),
    .now_time      (in_tdata[93:62]),
    .flush_timeout (timeout_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.more, out_r.clean, out_r.count, out_r.addr, out_r.file};

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while another is in progress");

  a_wo_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_WRITE_OUT) |-> !out_tlast)
    else $error("write-out marked as final result");

  a_more_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[63]) |-> (out_tuser == KIND_DONE && out_tlast))
    else $error("more pending outside a done result");

endmodule
